// ----- rtl/idmd_pkg.sv -----
// Package for the image difference mask block: sizes, codes, result and cell types.
// Used by every module of the block except the generic RAM.
`default_nettype none

package idmd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RADIUS     = 3;
    localparam int SPAN       = 2 * RADIUS + 1;
    localparam int HIST_W     = 2 * RADIUS;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 2;

    localparam int CNT_W      = $clog2(MAX_WIDTH + RADIUS);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + RADIUS);
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDEST_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W      = ((WIDEST_W > ROW_W) ? WIDEST_W : ROW_W) + 1;

    localparam int IN_DATA_W  = 6 * PIX_W;
    localparam int OUT_BITS   = 1 + 2 * COORD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int OUT_DEPTH  = 3;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(2);

    typedef struct packed {
        logic               mask_bit;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               last_of_frame;
    } result_t;

    typedef struct packed {
        logic            shift;
        logic [SPAN-1:0] row_ok;
    } cell_ctrl_t;

    // Rows of one window column that belong to the window with its corners cut.
    function automatic logic [SPAN-1:0] used_mask(input int col);
        int              ax;
        int              ay;
        logic [SPAN-1:0] m;
        ax = (col >= RADIUS) ? (col - RADIUS) : (RADIUS - col);
        for (int b = 0; b < SPAN; b++)
        begin
            ay = (b >= RADIUS) ? (b - RADIUS) : (RADIUS - b);
            m[b] = !((ax == RADIUS && ay > 1) || (ay == RADIUS && ax > 1));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/idmd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package is needed.
`default_nettype none

module idmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/idmd_cell.sv -----
// One column cell of the dilation window: holds one column vector and reports a hit.
// Depends on idmd_pkg.
`default_nettype none

module idmd_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire idmd_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         col_ok,
    input  wire logic [idmd_pkg::SPAN-1:0]    use_mask,
    input  wire logic [idmd_pkg::SPAN-1:0]    vec_in,
    output logic      [idmd_pkg::SPAN-1:0]    vec_out,
    output logic                              hit
);

    import idmd_pkg::*;

    logic [SPAN-1:0] vec_reg;
    logic [SPAN-1:0] vec_next;

    // The hit is taken on the vector that this cell holds after the shift.
    assign hit      = col_ok && (|(vec_in & use_mask & ctrl.row_ok));
    assign vec_next = ctrl.shift ? vec_in : vec_reg;
    assign vec_out  = vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/idmd_fifo.sv -----
// Small result queue that decouples the pipeline from the output handshake.
// Depends on idmd_pkg.
`default_nettype none

module idmd_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire idmd_pkg::result_t              push_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output idmd_pkg::result_t                   out_data,
    output logic      [idmd_pkg::OUT_CNT_W-1:0] count
);

    import idmd_pkg::*;

    result_t                entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/image_diff_mask_dilate_top.sv -----
// Top level of the image difference mask with dilation: counters, line store, cell row.
// Depends on idmd_pkg, idmd_ram, idmd_cell and idmd_fifo.
//
//  Channel  | Direction | Handshake                    | Contents
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | pixel pair, padding flag
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | mask bit, column, row, last
//  cfg      | in        | cfg_we                       | register index and value
//
// One item is accepted per cycle while s_axis_tready is high; a result reaches the
// output queue in the cycle after its item, and the line store is read at acceptance
// and written back in the next cycle. After reset the line store is cleared, with
// s_axis_tready held low. s_axis_tready comes from registers only and drops when the
// three-entry result queue, counting the result in flight, is full.
`default_nettype none

module image_diff_mask_dilate_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // orig_red, orig_green, orig_blue, mod_red, mod_green, mod_blue
    input  wire logic [idmd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // is_pad
    input  wire logic [0:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // mask_bit, out_col, out_row, zero fill
    output logic      [idmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [idmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [idmd_pkg::CFG_W-1:0]      cfg_data
);

    import idmd_pkg::*;

    logic                 partial_mode_reg;
    logic [CFG_W-1:0]     frame_width_reg;
    logic [CFG_W-1:0]     frame_height_reg;

    logic [CNT_W-1:0]     column_count_reg;
    logic [CNT_W-1:0]     column_count_next;
    logic [ROW_W-1:0]     row_count_reg;
    logic [ROW_W-1:0]     row_count_next;

    logic                 clr_busy_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;

    logic                 s1_valid_reg;
    logic                 s1_res_reg;
    logic                 s1_inw_reg;
    logic                 s1_d_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [SPAN-1:0]      s1_col_ok_reg;
    logic [SPAN-1:0]      s1_row_ok_reg;
    logic [COORD_W-1:0]   s1_x_reg;
    logic [COORD_W-1:0]   s1_y_reg;
    logic                 s1_last_reg;

    logic                 accept;
    logic [CMP_W-1:0]     fw;
    logic [CMP_W-1:0]     fh;
    logic [CMP_W-1:0]     we_eff;
    logic [CMP_W-1:0]     he_eff;
    logic [CMP_W-1:0]     cc;
    logic [CMP_W-1:0]     rr;
    logic [CMP_W-1:0]     xx;
    logic [CMP_W-1:0]     yy;
    logic [CMP_W-1:0]     c_n;
    logic [CMP_W-1:0]     r_n;
    logic                 in_w;
    logic                 in_h;
    logic                 differ;
    logic                 d_bit;
    logic                 res;
    logic                 last;
    logic [SPAN-1:0]      col_ok;
    logic [SPAN-1:0]      row_ok;

    logic [HIST_W-1:0]    ram_rdata;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [HIST_W-1:0]    ram_wdata;
    logic [SPAN-1:0]      vec;

    cell_ctrl_t           cell_ctrl;
    logic [SPAN-1:0]      link [SPAN];
    logic [SPAN-1:0]      hits;
    logic                 mask;

    result_t              push_data;
    result_t              out_data;
    logic                 push;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W:0]   occupancy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_mode_reg <= 1'b0;
            frame_width_reg  <= CFG_W'(FRAME_WIDTH_RESET);
            frame_height_reg <= CFG_W'(FRAME_HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PARTIAL_MODE: partial_mode_reg <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign occupancy     = {1'b0, fifo_count} + {{OUT_CNT_W{1'b0}}, (s1_valid_reg && s1_res_reg)};
    assign s_axis_tready = !clr_busy_reg && (occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        fw = CMP_W'(frame_width_reg);
        fh = CMP_W'(frame_height_reg);
        priority if (fw == '0)
            we_eff = CMP_W'(1);
        else if (fw > CMP_W'(MAX_WIDTH))
            we_eff = CMP_W'(MAX_WIDTH);
        else
            we_eff = fw;
        priority if (fh == '0)
            he_eff = CMP_W'(1);
        else if (fh > CMP_W'(MAX_HEIGHT))
            he_eff = CMP_W'(MAX_HEIGHT);
        else
            he_eff = fh;

        cc     = CMP_W'(column_count_reg);
        rr     = CMP_W'(row_count_reg);
        xx     = cc - CMP_W'(RADIUS);
        yy     = rr - CMP_W'(RADIUS);
        in_w   = cc < we_eff;
        in_h   = rr < he_eff;
        differ = s_axis_tdata[3*PIX_W-1:0] != s_axis_tdata[6*PIX_W-1:3*PIX_W];
        d_bit  = !s_axis_tuser[0] && in_w && in_h && differ;
        res    = (cc >= CMP_W'(RADIUS)) && (rr >= CMP_W'(RADIUS))
                 && (xx < we_eff) && (yy < he_eff);
        last   = (xx == we_eff - 1'b1) && (yy == he_eff - 1'b1);
        for (int i = 0; i < SPAN; i++)
        begin
            col_ok[i] = cc >= CMP_W'(i);
            row_ok[i] = rr >= CMP_W'(i);
        end

        c_n = cc + 1'b1;
        r_n = rr;
        if (c_n >= we_eff + CMP_W'(RADIUS))
        begin
            c_n = '0;
            r_n = rr + 1'b1;
        end
        if (r_n >= he_eff + CMP_W'(RADIUS))
        begin
            r_n = '0;
        end
        column_count_next = c_n[CNT_W-1:0];
        row_count_next    = r_n[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            clr_busy_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s1_res_reg       <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
            end
            s1_valid_reg <= accept;
            s1_res_reg   <= accept && res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inw_reg    <= in_w;
            s1_d_reg      <= d_bit;
            s1_addr_reg   <= column_count_reg[ADDR_W-1:0];
            s1_col_ok_reg <= col_ok;
            s1_row_ok_reg <= row_ok;
            s1_x_reg      <= xx[COORD_W-1:0];
            s1_y_reg      <= yy[COORD_W-1:0];
            s1_last_reg   <= last;
        end
    end

    // Each column keeps the difference bits of the rows above it.
    assign vec       = s1_inw_reg ? {ram_rdata, s1_d_reg} : '0;
    assign ram_we    = clr_busy_reg || (s1_valid_reg && s1_inw_reg);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_busy_reg ? '0 : vec[HIST_W-1:0];

    idmd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (column_count_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign cell_ctrl.shift  = s1_valid_reg;
    assign cell_ctrl.row_ok = s1_row_ok_reg;
    assign link[0]          = vec;

    for (genvar k = 0; k < SPAN; k++)
    begin : g_cell
        if (k < SPAN - 1)
        begin : g_mid
            idmd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .col_ok   (s1_col_ok_reg[k]),
                .use_mask (used_mask(k)),
                .vec_in   (link[k]),
                .vec_out  (link[k+1]),
                .hit      (hits[k])
            );
        end
        else
        begin : g_end
            idmd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .col_ok   (s1_col_ok_reg[k]),
                .use_mask (used_mask(k)),
                .vec_in   (link[k]),
                .vec_out  (),
                .hit      (hits[k])
            );
        end
    end

    assign mask = partial_mode_reg ? (|hits) : link[RADIUS][RADIUS];

    assign push                   = s1_valid_reg && s1_res_reg;
    assign push_data.mask_bit      = mask;
    assign push_data.out_col       = s1_x_reg;
    assign push_data.out_row       = s1_y_reg;
    assign push_data.last_of_frame = s1_last_reg;

    idmd_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {(OUT_DATA_W - OUT_BITS)'(0), out_data.out_row,
                           out_data.out_col, out_data.mask_bit};
    assign m_axis_tlast = out_data.last_of_frame;

    // A result in flight always finds room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s1_res_reg && fifo_count == OUT_CNT_W'(OUT_DEPTH)))
        else $error("Result queue overflow.");

    // The clearing pass and the line store write-back never share the write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_busy_reg && s1_valid_reg))
        else $error("Line store write collision.");

    // A new read never targets the column whose history is being written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && s1_inw_reg) |->
            (column_count_reg[ADDR_W-1:0] != s1_addr_reg))
        else $error("Line store read-after-write hazard.");

    // An item that produces a result is queued in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res) |=> push)
        else $error("Result lost between acceptance and queue.");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for image_diff_mask_dilate_top: streams padded pixel-pair frames
// and checks every mask item against an in-bench model of the difference and dilation.
// Depends on idmd_pkg and the RTL of the block; needs no files or arguments.
`default_nettype none

module tb_top;

    localparam int RAD           = idmd_pkg::RADIUS;
    localparam int WIN           = idmd_pkg::SPAN;
    localparam int RANDOM_ITEMS  = 360;
    localparam int WIDE_ITEMS    = 40;
    localparam int TALL_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 30;

    typedef struct packed {
        logic [7:0] orig_red;
        logic [7:0] orig_green;
        logic [7:0] orig_blue;
        logic [7:0] mod_red;
        logic [7:0] mod_green;
        logic [7:0] mod_blue;
        logic       is_pad;
    } pixel_item_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [idmd_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [idmd_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              cfg_we = 1'b0;
    logic [idmd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [idmd_pkg::CFG_W-1:0]        cfg_data = '0;

    // Model state of the block.
    logic                              cfg_partial = 1'b0;
    logic [idmd_pkg::CFG_W-1:0]        cfg_width = idmd_pkg::CFG_W'(idmd_pkg::FRAME_WIDTH_RESET);
    logic [idmd_pkg::CFG_W-1:0]        cfg_height = idmd_pkg::CFG_W'(idmd_pkg::FRAME_HEIGHT_RESET);
    logic [2*RAD-1:0]                  column_history [0:idmd_pkg::MAX_WIDTH-1];
    logic [WIN*WIN-1:0]                window_bits = '0;
    int                                pos_col = 0;
    int                                pos_row = 0;

    // Stimulus side.
    pixel_item_t                       pixel_queue [$];
    idmd_pkg::result_t                 pending_masks [$];
    pixel_item_t                       driven_pixel;
    int                                gen_col = 0;
    int                                gen_row = 0;
    int                                queued_items = 0;
    int                                settings_count = 0;
    bit                                tx_steady = 1'b0;
    bit                                rx_steady = 1'b0;
    int                                hold_requests = 0;
    int                                hold_served = 0;
    int                                tx_gap = 0;
    int                                rx_stall = 0;
    int                                rx_hold = 0;
    int                                idle_cycles = 0;
    int                                items_sent = 0;
    int                                masks_checked = 0;
    int                                error_count = 0;

    image_diff_mask_dilate_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_width();
        int v;
        v = cfg_width;
        if (v < 1)
            v = 1;
        if (v > idmd_pkg::MAX_WIDTH)
            v = idmd_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int eff_height();
        int v;
        v = cfg_height;
        if (v < 1)
            v = 1;
        if (v > idmd_pkg::MAX_HEIGHT)
            v = idmd_pkg::MAX_HEIGHT;
        return v;
    endfunction

    function automatic bit corner_cut(input int dx, input int dy);
        int ax;
        int ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return (ax == RAD && ay > 1) || (ay == RAD && ax > 1);
    endfunction

    // Raster advance over the padded grid; a counter beyond a shrunken grid wraps here.
    task automatic step_position(inout int col, inout int row);
        col++;
        if (col >= eff_width() + RAD)
        begin
            col = 0;
            row++;
            if (row >= eff_height() + RAD)
                row = 0;
        end
        if (row >= eff_height() + RAD)
            row = 0;
    endtask

    task automatic predict_mask(input pixel_item_t px);
        int                w;
        int                h;
        int                x;
        int                y;
        logic              differs;
        logic [WIN-1:0]    vec;
        logic              m;
        idmd_pkg::result_t res;
        w = eff_width();
        h = eff_height();
        differs = !px.is_pad && pos_col < w && pos_row < h &&
                  ({px.orig_red, px.orig_green, px.orig_blue} !=
                   {px.mod_red, px.mod_green, px.mod_blue});
        vec = '0;
        if (pos_col < w)
        begin
            vec = {column_history[pos_col], differs};
            column_history[pos_col] = vec[2*RAD-1:0];
        end
        window_bits = {window_bits[WIN*WIN-WIN-1:0], vec};
        if (pos_col >= RAD && pos_row >= RAD && pos_col - RAD < w && pos_row - RAD < h)
        begin
            x = pos_col - RAD;
            y = pos_row - RAD;
            m = 1'b0;
            if (cfg_partial)
            begin
                // Cells left of or above the frame are outside and count as zero.
                for (int i = 0; i < WIN; i++)
                    for (int b = 0; b < WIN; b++)
                        if (pos_col >= i && pos_row >= b && !corner_cut(i - RAD, b - RAD))
                            m = m | window_bits[i*WIN+b];
            end
            else
                m = window_bits[RAD*WIN+RAD];
            res.mask_bit      = m;
            res.out_col       = x[idmd_pkg::COORD_W-1:0];
            res.out_row       = y[idmd_pkg::COORD_W-1:0];
            res.last_of_frame = (x == w - 1) && (y == h - 1);
            pending_masks.push_back(res);
        end
        step_position(pos_col, pos_row);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH: %s", what);
    endtask

    // Driver: offers queued pixel items, holds an item until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_mask(driven_pixel);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    driven_pixel = pixel_queue.pop_front();
                    s_axis_tdata <= {driven_pixel.mod_blue, driven_pixel.mod_green,
                                     driven_pixel.mod_red, driven_pixel.orig_blue,
                                     driven_pixel.orig_green, driven_pixel.orig_red};
                    s_axis_tuser <= driven_pixel.is_pad;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = tx_steady ? 0 : pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            rx_hold = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_steady)
            m_axis_tready <= 1'b1;
        else
        begin
            rx_stall = pick_gap();
            m_axis_tready <= (rx_stall == 0);
            if (rx_stall > 0)
                rx_stall--;
        end
    end

    // Monitor: checks each mask item against the oldest expectation.
    always @(posedge clk)
    begin
        idmd_pkg::result_t got;
        idmd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.mask_bit      = m_axis_tdata[0];
            got.out_col       = m_axis_tdata[idmd_pkg::COORD_W:1];
            got.out_row       = m_axis_tdata[2*idmd_pkg::COORD_W:idmd_pkg::COORD_W+1];
            got.last_of_frame = m_axis_tlast;
            if (pending_masks.size() == 0)
                report_mismatch($sformatf("unexpected mask item at (%0d,%0d)",
                                          got.out_col, got.out_row));
            else
            begin
                want = pending_masks.pop_front();
                masks_checked++;
                if (got.mask_bit !== want.mask_bit)
                    report_mismatch($sformatf("mask_bit at (%0d,%0d): got %0b, expected %0b",
                                              want.out_col, want.out_row,
                                              got.mask_bit, want.mask_bit));
                if (got.out_col !== want.out_col)
                    report_mismatch($sformatf("out_col: got %0d, expected %0d",
                                              got.out_col, want.out_col));
                if (got.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row: got %0d, expected %0d",
                                              got.out_row, want.out_row));
                if (got.last_of_frame !== want.last_of_frame)
                    report_mismatch($sformatf("last_of_frame at (%0d,%0d): got %0b, expected %0b",
                                              want.out_col, want.out_row,
                                              got.last_of_frame, want.last_of_frame));
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_masks.size());
            $display("** image_diff_mask_dilate_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [idmd_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= idmd_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == idmd_pkg::CFG_PARTIAL_MODE)
            cfg_partial = value[0];
        else if (idx == idmd_pkg::CFG_FRAME_WIDTH)
            cfg_width = idmd_pkg::CFG_W'(value);
        else if (idx == idmd_pkg::CFG_FRAME_HEIGHT)
            cfg_height = idmd_pkg::CFG_W'(value);
    endtask

    task automatic apply_setting(input int mode, input int width, input int height);
        write_reg(idmd_pkg::CFG_PARTIAL_MODE, mode);
        write_reg(idmd_pkg::CFG_FRAME_WIDTH, width);
        write_reg(idmd_pkg::CFG_FRAME_HEIGHT, height);
        settings_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || pending_masks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic pixel_item_t make_pixel(input bit in_frame, input int diff_pct);
        pixel_item_t px;
        int          chans;
        px.orig_red   = $urandom_range(0, 255);
        px.orig_green = $urandom_range(0, 255);
        px.orig_blue  = $urandom_range(0, 255);
        px.mod_red    = px.orig_red;
        px.mod_green  = px.orig_green;
        px.mod_blue   = px.orig_blue;
        if (in_frame)
        begin
            px.is_pad = ($urandom_range(0, 99) < 4);
            if ($urandom_range(0, 99) < diff_pct)
            begin
                chans = $urandom_range(1, 7);
                if (chans[0])
                    px.mod_red = px.orig_red ^ 8'($urandom_range(1, 255));
                if (chans[1])
                    px.mod_green = px.orig_green ^ 8'($urandom_range(1, 255));
                if (chans[2])
                    px.mod_blue = px.orig_blue ^ 8'($urandom_range(1, 255));
            end
        end
        else
        begin
            // Padding positions carry noise that the block must ignore.
            px.is_pad = ($urandom_range(0, 99) < 80);
            if ($urandom_range(0, 1))
            begin
                px.mod_red   = $urandom_range(0, 255);
                px.mod_green = $urandom_range(0, 255);
                px.mod_blue  = $urandom_range(0, 255);
            end
        end
        return px;
    endfunction

    task automatic push_item(input int diff_pct);
        pixel_queue.push_back(make_pixel(gen_col < eff_width() && gen_row < eff_height(),
                                         diff_pct));
        queued_items++;
        step_position(gen_col, gen_row);
    endtask

    task automatic push_frame(input int diff_pct);
        push_item(diff_pct);
        while (gen_col != 0 || gen_row != 0)
            push_item(diff_pct);
    endtask

    // Frame pixels all-ones against all-zeros; padding differs the other way round.
    task automatic push_directed_frame(input bit pad_frame_pixels);
        pixel_item_t px;
        bit          in_frame;
        do
        begin
            in_frame = gen_col < eff_width() && gen_row < eff_height();
            px.orig_red   = in_frame ? 8'hFF : 8'h00;
            px.orig_green = in_frame ? 8'hFF : 8'h00;
            px.orig_blue  = in_frame ? 8'hFF : 8'h00;
            px.mod_red    = ~px.orig_red;
            px.mod_green  = ~px.orig_green;
            px.mod_blue   = ~px.orig_blue;
            px.is_pad     = in_frame && pad_frame_pixels;
            pixel_queue.push_back(px);
            queued_items++;
            step_position(gen_col, gen_row);
        end
        while (gen_col != 0 || gen_row != 0);
    endtask

    initial
    begin
        int random_base;
        int mode;
        int width;
        int height;
        int frames;
        int diff_pct;
        for (int i = 0; i < idmd_pkg::MAX_WIDTH; i++)
            column_history[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);

        // Zero sizes are taken as one; padding that differs must stay out of the mask.
        apply_setting(0, 0, 0);
        push_directed_frame(1'b0);
        wait_idle();
        // A flagged frame pixel counts as unchanged, even under dilation.
        apply_setting(1, 1, 1);
        push_directed_frame(1'b1);
        wait_idle();

        // An oversized width is clamped; part of one wide row, then the counters run on
        // into a tall narrow frame and wrap there.
        apply_setting(1, 2047, 1);
        for (int k = 0; k < WIDE_ITEMS; k++)
            push_item(10);
        wait_idle();
        apply_setting(1, 1, idmd_pkg::MAX_HEIGHT);
        for (int k = 0; k < TALL_ITEMS; k++)
            push_item(10);
        wait_idle();

        // Back-pressure: the sender keeps offering while the receiver holds off.
        random_base = queued_items;
        apply_setting(1, 12, 8);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        push_frame(15);
        hold_requests++;
        wait_idle();

        while (queued_items - random_base < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: width = $urandom_range(1, 12);
                7, 8:                width = $urandom_range(13, 40);
                default:             width = 0;
            endcase
            case ($urandom_range(0, 9))
                8:       height = $urandom_range(9, 16);
                9:       height = 0;
                default: height = $urandom_range(1, 8);
            endcase
            apply_setting(mode, width, height);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            diff_pct = $urandom_range(0, 35);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++)
                push_frame(diff_pct);
            // Now and then stop mid-frame, so the next setting lands on running counters.
            if ($urandom_range(0, 4) == 0)
                for (int k = $urandom_range(1, (eff_width() + RAD) * (eff_height() + RAD) - 1);
                     k > 0; k--)
                    push_item(diff_pct);
            wait_idle();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        $display("Run covered %0d pixel items and %0d mask items over %0d register settings,",
                 items_sent, masks_checked, settings_count);
        $display("exact and dilated modes, clamped sizes, mid-frame setting changes.");
        if (error_count == 0)
            $display("** image_diff_mask_dilate_top: PASSED **");
        else
            $display("** image_diff_mask_dilate_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/idmd_pkg.sv
rtl/idmd_ram.sv
rtl/idmd_cell.sv
rtl/idmd_fifo.sv
rtl/image_diff_mask_dilate_top.sv
sim/tb_top.sv
